@@ sv/nps_pkg.sv @@
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int unsigned MAX_PROCS_DEF = 16;

    localparam logic [7:0] SWITCH_COST_RST = 8'd1;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_SWITCH_COST = 3'd0;

    typedef struct packed {
        logic [15:0] process_id;
        logic [7:0]  prio_level;
        logic [15:0] burst_length;
        logic [15:0] arrival_time;
        logic        load_last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] sched_id;
        logic [31:0] start_time;
        logic [31:0] wait_time;
        logic [31:0] finish_time;
        logic        sched_last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] arrival;
    } t_entry;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

endpackage

@@ sv/nps_front.sv @@
// ----------------------------------------------------------------------------
// nps_front
// Two-entry input queue that takes load transactions and hands them to the
// scheduler core, so that loading can proceed while the core is busy.
// ----------------------------------------------------------------------------
module nps_front
    import nps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output t_queue_head o_head,
    input  logic        i_pop
);

    t_in_item   r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_in_ready   = (r_cnt != 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_slot[r_rp];

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_head.valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_in_data;
        end
    end

endmodule

@@ sv/nps_sched.sv @@
// ----------------------------------------------------------------------------
// nps_sched
// Scheduler core: stores the process table, scans it for each decision
// (once more when nothing has arrived yet) and emits one result
// transaction per scheduled process through an output register.
// ----------------------------------------------------------------------------
module nps_sched
    import nps_pkg::*;
#(
    parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    input  logic [7:0]  i_switch_cost,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_PROCS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    t_entry                 r_mem [MAX_PROCS];
    t_entry                 r_rd;
    logic [1:0]             r_state;
    logic [MAX_PROCS-1:0]   r_pend;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_remain;
    logic [CW-1:0]          r_issue;
    logic                   r_chk_v;
    logic [IW-1:0]          r_chk_idx;
    logic [31:0]            r_clock;
    logic [15:0]            r_earliest;
    logic                   r_found;
    logic [IW-1:0]          r_bidx;
    logic [15:0]            r_bid;
    logic [7:0]             r_bprio;
    logic [15:0]            r_bburst;
    logic [15:0]            r_barr;
    logic [31:0]            r_start;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   mem_we;
    logic                   take;
    logic                   better;
    logic                   scan_done;
    logic                   out_free;
    logic                   emit;
    logic [31:0]            finish;

    assign o_pop       = (r_state == S_IDLE);
    assign mem_we      = (r_state == S_IDLE) && i_head.valid && (r_count < COUNT_FULL);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;
    assign emit        = (r_state == S_EMIT) && out_free;
    assign finish      = sat_add(r_start, {16'd0, r_bburst});

    assign take      = r_chk_v && r_pend[r_chk_idx];
    assign better    = !r_found || (r_rd.prio > r_bprio) ||
                       ((r_rd.prio == r_bprio) && (r_rd.arrival < r_barr));
    assign scan_done = (r_issue == r_count) && !r_chk_v;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IW-1:0]] <= '{id:      i_head.item.process_id,
                                       prio:    i_head.item.prio_level,
                                       burst:   i_head.item.burst_length,
                                       arrival: i_head.item.arrival_time};
        end
        r_rd <= r_mem[r_issue[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_count     <= '0;
            r_remain    <= '0;
            r_issue     <= '0;
            r_chk_v     <= 1'b0;
            r_chk_idx   <= '0;
            r_clock     <= '0;
            r_earliest  <= 16'hFFFF;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        if (mem_we) begin
                            r_pend[r_count[IW-1:0]] <= 1'b1;
                            r_count                 <= r_count + 1'b1;
                        end
                        if (i_head.item.load_last) begin
                            r_remain   <= mem_we ? r_count + 1'b1 : r_count;
                            r_issue    <= '0;
                            r_chk_v    <= 1'b0;
                            r_found    <= 1'b0;
                            r_earliest <= 16'hFFFF;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue != r_count) begin
                        r_chk_idx <= r_issue[IW-1:0];
                        r_issue   <= r_issue + 1'b1;
                        r_chk_v   <= 1'b1;
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                    if (take) begin
                        if (r_rd.arrival < r_earliest) begin
                            r_earliest <= r_rd.arrival;
                        end
                        if (({16'd0, r_rd.arrival} <= r_clock) && better) begin
                            r_found  <= 1'b1;
                            r_bidx   <= r_chk_idx;
                            r_bid    <= r_rd.id;
                            r_bprio  <= r_rd.prio;
                            r_bburst <= r_rd.burst;
                            r_barr   <= r_rd.arrival;
                        end
                    end
                    if (scan_done) begin
                        r_state <= (r_remain == '0) ? S_IDLE : S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_found) begin
                        r_start <= sat_add(r_clock, {24'd0, i_switch_cost});
                        r_state <= S_EMIT;
                    end else begin
                        r_clock    <= {16'd0, r_earliest};
                        r_issue    <= '0;
                        r_earliest <= 16'hFFFF;
                        r_state    <= S_SCAN;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.sched_id    <= r_bid;
                        r_out.start_time  <= r_start;
                        r_out.wait_time   <= r_start - {16'd0, r_barr};
                        r_out.finish_time <= finish;
                        r_out.sched_last  <= (r_remain == CW'(1));
                        r_remain          <= r_remain - 1'b1;
                        r_found           <= 1'b0;
                        r_issue           <= '0;
                        r_earliest        <= 16'hFFFF;
                        if (r_remain == CW'(1)) begin
                            r_pend  <= '0;
                            r_count <= '0;
                            r_clock <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pend[r_bidx] <= 1'b0;
                            r_clock        <= finish;
                            r_state        <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/nonpreemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Processes are loaded into the core through a two-entry queue. Each
// scheduling decision scans the loaded table, then computes and registers
// the result; a decision that finds nothing ready costs one more scan.
// Reset is synchronous and active low; it empties the table and sets
// switch_cost to 1.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
#(
    parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0]  r_switch_cost;
    t_queue_head head;
    logic        pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SWITCH_COST) ? {24'd0, r_switch_cost} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_cost <= SWITCH_COST_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == ADDR_SWITCH_COST[PADDR_W-1:2])) begin
            r_switch_cost <= pwdata[7:0];
        end
    end

    nps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_head     (head),
        .i_pop      (pop)
    );

    nps_sched #(
        .MAX_PROCS (MAX_PROCS)
    ) u_sched (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_switch_cost (r_switch_cost),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule
